// ===== hw/rtl/xyzlab_pkg.sv =====
package xyzlab_pkg;

  // Field and register widths.
  localparam int TRI_W     = 16;
  localparam int RECIP_W   = 24;
  localparam int OUT_W     = 18;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_RECIP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RECIP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_RECIP = 2'd2;

  // D65 white point reciprocals, unsigned Q0.24.
  localparam logic [RECIP_W-1:0] X_RECIP_RST = 24'd176516;
  localparam logic [RECIP_W-1:0] Y_RECIP_RST = 24'd167772;
  localparam logic [RECIP_W-1:0] Z_RECIP_RST = 24'd154084;

  // Normalized value t, signed Q.24, and the scaling product.
  localparam int SCALE_W   = TRI_W + RECIP_W + 1;
  localparam int T_SH      = 8;
  localparam int T_W       = 32;
  localparam logic signed [T_W-1:0] CBRT_THRESH = 32'sd148579;

  // Linear segment: 7.787 in Q16, then 16/116 in Q18.
  localparam int LIN_K_W   = 20;
  localparam int LIN_P_W   = T_W + LIN_K_W;
  localparam int LIN_SH    = 22;
  localparam logic signed [LIN_K_W-1:0] LIN_K   = 20'sd510329;
  localparam int F_W       = 32;
  localparam logic signed [F_W-1:0]     LIN_OFS = 32'sd36158;

  // Cube root of t * 2^30, three radicand bits per stage.
  localparam int RAD_W       = 31;
  localparam int CBRT_FRAC   = 30;
  localparam int CBRT_STAGES = 21;
  localparam int CBRT_M_W    = 3 * CBRT_STAGES;
  localparam int ROOT_W      = CBRT_STAGES;
  localparam int SQ_W        = 2 * ROOT_W;
  localparam int REM_W       = SQ_W + 6;

  // Output arithmetic.
  localparam int PROD_W = 42;
  localparam int OUT_SH = 10;
  localparam logic signed [PROD_W-1:0] L_GAIN     = 42'sd116;
  localparam logic signed [PROD_W-1:0] A_GAIN     = 42'sd500;
  localparam logic signed [PROD_W-1:0] B_GAIN     = 42'sd200;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 42'sd512;
  localparam logic signed [PROD_W-1:0] L_OFS      = -42'sd4096;
  localparam logic signed [PROD_W-1:0] NO_OFS     = 42'sd0;
  localparam logic signed [PROD_W-1:0] SAT_HI     = 42'sd131071;
  localparam logic signed [PROD_W-1:0] SAT_LO     = -42'sd131072;

  // Register stages from input acceptance to the output register.
  localparam int PIPE_DEPTH = 2 + CBRT_STAGES + 2;

  // Round to Q10.8, add the offset and clamp to the output range.
  function automatic logic signed [OUT_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] p,
    input logic signed [PROD_W-1:0] ofs
  );
    logic signed [PROD_W-1:0] q;
    q = ((p + ROUND_HALF) >>> OUT_SH) + ofs;
    if (q > SAT_HI) begin
      round_sat = SAT_HI[OUT_W-1:0];
    end else if (q < SAT_LO) begin
      round_sat = SAT_LO[OUT_W-1:0];
    end else begin
      round_sat = q[OUT_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/xyzlab_if.sv =====
interface xyzlab_in_if;
  import xyzlab_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TRI_W-1:0] x_tristim;
  logic signed [TRI_W-1:0] y_tristim;
  logic signed [TRI_W-1:0] z_tristim;

  modport source (output valid, output x_tristim, output y_tristim, output z_tristim,
                  input ready);
  modport sink (input valid, input x_tristim, input y_tristim, input z_tristim,
                output ready);
endinterface

interface xyzlab_out_if;
  import xyzlab_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] l_star;
  logic signed [OUT_W-1:0] a_star;
  logic signed [OUT_W-1:0] b_star;

  modport source (output valid, output l_star, output a_star, output b_star,
                  input ready);
  modport sink (input valid, input l_star, input a_star, input b_star,
                output ready);
endinterface

// ===== hw/rtl/xyz_to_cielab_converter.sv =====
// XYZ to CIELAB converter. Each accepted item is one pixel of signed Q8.8
// X, Y, Z on a 0..100 scale; each result is L*, a*, b* in signed Q10.8,
// rounded and saturated. The block takes one pixel per clock and returns
// each result in the order of acceptance; the pipeline depth is set
// mostly by the cube root, which resolves one 3-bit digit of the radicand
// per stage over 21 stages. When the output is held, the whole pipeline
// freezes and in_px.ready drops in the same cycle, so nothing is lost or
// repeated. The white reciprocals come up as D65 at reset and may be
// rewritten through the cfg port while no pixel is in flight; no warm-up or
// clearing time is needed after reset.
module xyz_to_cielab_converter (
  input  logic                                clk,
  input  logic                                rst_n,
  xyzlab_in_if.sink                           in_px,
  xyzlab_out_if.source                        out_px,
  input  logic                                cfg_we,
  input  logic [xyzlab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [xyzlab_pkg::RECIP_W-1:0]      cfg_wdata
);
  import xyzlab_pkg::*;

  logic [RECIP_W-1:0]    x_recip_r;
  logic [RECIP_W-1:0]    y_recip_r;
  logic [RECIP_W-1:0]    z_recip_r;
  logic [PIPE_DEPTH-1:0] valid_r;
  logic [PIPE_DEPTH-1:0] valid_nxt;
  logic                  en;
  logic signed [F_W-1:0] fx;
  logic signed [F_W-1:0] fy;
  logic signed [F_W-1:0] fz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_recip_r <= X_RECIP_RST;
      y_recip_r <= Y_RECIP_RST;
      z_recip_r <= Z_RECIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_RECIP: x_recip_r <= cfg_wdata;
        CFG_Y_RECIP: y_recip_r <= cfg_wdata;
        CFG_Z_RECIP: z_recip_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the output register can take data.
  assign en        = !valid_r[PIPE_DEPTH-1] || out_px.ready;
  assign valid_nxt = {valid_r[PIPE_DEPTH-2:0], in_px.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  assign in_px.ready  = en;
  assign out_px.valid = valid_r[PIPE_DEPTH-1];

  xyzlab_compand u_comp_x (
    .clk    (clk),
    .en     (en),
    .tri_in (in_px.x_tristim),
    .recip  (x_recip_r),
    .f_out  (fx)
  );

  xyzlab_compand u_comp_y (
    .clk    (clk),
    .en     (en),
    .tri_in (in_px.y_tristim),
    .recip  (y_recip_r),
    .f_out  (fy)
  );

  xyzlab_compand u_comp_z (
    .clk    (clk),
    .en     (en),
    .tri_in (in_px.z_tristim),
    .recip  (z_recip_r),
    .f_out  (fz)
  );

  xyzlab_finish u_finish (
    .clk    (clk),
    .en     (en),
    .fx     (fx),
    .fy     (fy),
    .fz     (fz),
    .l_star (out_px.l_star),
    .a_star (out_px.a_star),
    .b_star (out_px.b_star)
  );

  // A held result must stop intake in the same cycle.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_px.valid && !out_px.ready) |-> !in_px.ready)
    else $error("input accepted while the output is held");

  // An empty pipeline with no new pixel stays empty.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r == '0 && !in_px.valid) |=> (valid_r == '0))
    else $error("item appeared without an accepted input");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_px.valid)
    else $error("result valid right after reset");

endmodule

// ===== hw/rtl/xyzlab_compand.sv =====
module xyzlab_compand (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [xyzlab_pkg::TRI_W-1:0] tri_in,
  input  logic [xyzlab_pkg::RECIP_W-1:0]      recip,
  output logic signed [xyzlab_pkg::F_W-1:0]   f_out
);
  import xyzlab_pkg::*;

  logic signed [SCALE_W-1:0] scale_prod;
  logic signed [T_W-1:0]     t24_r;
  logic signed [LIN_P_W-1:0] lin_prod_r;
  logic                      cube0_r;
  logic [RAD_W-1:0]          rad0_r;
  logic signed [F_W-1:0]     flin0;

  logic [ROOT_W-1:0]     root_r [CBRT_STAGES];
  logic                  cube_r [CBRT_STAGES];
  logic signed [F_W-1:0] flin_r [CBRT_STAGES];
  logic [REM_W-1:0]      rem_r  [CBRT_STAGES-1];
  logic [SQ_W-1:0]       sq_r   [CBRT_STAGES-1];
  logic [RAD_W-1:0]      rad_r  [CBRT_STAGES-1];

  // Scale by the white reciprocal; the arithmetic shift is the floor.
  assign scale_prod = tri_in * $signed({1'b0, recip});

  always_ff @(posedge clk) begin
    if (en) begin
      t24_r      <= scale_prod[T_SH+T_W-1:T_SH];
      lin_prod_r <= LIN_P_W'(t24_r) * LIN_P_W'(LIN_K);
      cube0_r    <= (t24_r > CBRT_THRESH);
      rad0_r     <= (t24_r > CBRT_THRESH) ? t24_r[RAD_W-1:0] : '0;
    end
  end

  assign flin0 = F_W'($signed(lin_prod_r[LIN_P_W-1:LIN_SH])) + LIN_OFS;

  // Restoring cube root, one radicand digit per stage. The remainder holds
  // m - y^3 for the bits seen so far and sq tracks y^2, so no multiplier.
  for (genvar k = 0; k < CBRT_STAGES; k++) begin : g_digit
    localparam int D = CBRT_STAGES - 1 - k;

    logic [REM_W-1:0]      rem_in;
    logic [ROOT_W-1:0]     root_in;
    logic [SQ_W-1:0]       sq_in;
    logic [RAD_W-1:0]      rad_in;
    logic                  cube_in;
    logic signed [F_W-1:0] flin_in;
    logic [CBRT_M_W-1:0]   m;
    logic [2:0]            digit;
    logic [ROOT_W-1:0]     y2;
    logic [SQ_W-1:0]       s4;
    logic [REM_W-1:0]      rs;
    logic [REM_W-1:0]      b;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sq_in   = '0;
      assign rad_in  = rad0_r;
      assign cube_in = cube0_r;
      assign flin_in = flin0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sq_in   = sq_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign cube_in = cube_r[k-1];
      assign flin_in = flin_r[k-1];
    end

    assign m     = {{(CBRT_M_W-RAD_W-CBRT_FRAC){1'b0}}, rad_in, {CBRT_FRAC{1'b0}}};
    assign digit = m[3*D +: 3];
    assign y2    = {root_in[ROOT_W-2:0], 1'b0};
    assign s4    = {sq_in[SQ_W-3:0], 2'b00};
    assign rs    = {rem_in[REM_W-4:0], digit};
    // (2y+1)^3 - (2y)^3 = 3*(2y)^2 + 3*(2y) + 1
    assign b     = (REM_W'(s4) << 1) + REM_W'(s4) + (REM_W'(y2) << 1) + REM_W'(y2)
                   + REM_W'(1);
    assign ge    = (rs >= b);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= y2 + ROOT_W'(ge);
        cube_r[k] <= cube_in;
        flin_r[k] <= flin_in;
      end
    end

    if (k < CBRT_STAGES - 1) begin : g_carry
      logic [REM_W-1:0] rem_nxt;
      logic [SQ_W-1:0]  sq_nxt;

      assign rem_nxt = ge ? (rs - b) : rs;
      assign sq_nxt  = ge ? (s4 + (SQ_W'(y2) << 1) + SQ_W'(1)) : s4;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          sq_r[k]  <= sq_nxt;
          rad_r[k] <= rad_in;
        end
      end
    end
  end

  assign f_out = cube_r[CBRT_STAGES-1]
               ? $signed({{(F_W-ROOT_W){1'b0}}, root_r[CBRT_STAGES-1]})
               : flin_r[CBRT_STAGES-1];

endmodule

// ===== hw/rtl/xyzlab_finish.sv =====
module xyzlab_finish (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [xyzlab_pkg::F_W-1:0]   fx,
  input  logic signed [xyzlab_pkg::F_W-1:0]   fy,
  input  logic signed [xyzlab_pkg::F_W-1:0]   fz,
  output logic signed [xyzlab_pkg::OUT_W-1:0] l_star,
  output logic signed [xyzlab_pkg::OUT_W-1:0] a_star,
  output logic signed [xyzlab_pkg::OUT_W-1:0] b_star
);
  import xyzlab_pkg::*;

  logic signed [PROD_W-1:0] dxy;
  logic signed [PROD_W-1:0] dyz;
  logic signed [PROD_W-1:0] l_prod_r;
  logic signed [PROD_W-1:0] a_prod_r;
  logic signed [PROD_W-1:0] b_prod_r;
  logic signed [OUT_W-1:0]  l_star_r;
  logic signed [OUT_W-1:0]  a_star_r;
  logic signed [OUT_W-1:0]  b_star_r;

  assign dxy = PROD_W'(fx) - PROD_W'(fy);
  assign dyz = PROD_W'(fy) - PROD_W'(fz);

  always_ff @(posedge clk) begin
    if (en) begin
      l_prod_r <= PROD_W'(fy) * L_GAIN;
      a_prod_r <= dxy * A_GAIN;
      b_prod_r <= dyz * B_GAIN;
      l_star_r <= round_sat(l_prod_r, L_OFS);
      a_star_r <= round_sat(a_prod_r, NO_OFS);
      b_star_r <= round_sat(b_prod_r, NO_OFS);
    end
  end

  assign l_star = l_star_r;
  assign a_star = a_star_r;
  assign b_star = b_star_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import xyzlab_pkg::*;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam longint CBRT_KNEE_Q24 = 148579;
  localparam longint SLOPE_Q16     = 510329;
  localparam longint KNEE_BASE_Q18 = 36158;
  localparam longint L_SCALE       = 116;
  localparam longint A_SCALE       = 500;
  localparam longint B_SCALE       = 200;
  localparam longint L_OFFSET      = -4096;
  localparam longint LAB_MAX       = 131071;
  localparam longint LAB_MIN       = -131072;

  localparam int STALL_LIMIT      = 2000;
  localparam int PHASES           = 10;
  localparam int RANDOM_PER_PHASE = 120;

  typedef struct packed {
    logic signed [OUT_W-1:0] l_star;
    logic signed [OUT_W-1:0] a_star;
    logic signed [OUT_W-1:0] b_star;
  } lab_t;

  class lab_scoreboard;
    logic [RECIP_W-1:0] white_x;
    logic [RECIP_W-1:0] white_y;
    logic [RECIP_W-1:0] white_z;
    lab_t               pending_lab[$];
    int                 errors;

    function new();
      white_x = X_RECIP_RST;
      white_y = Y_RECIP_RST;
      white_z = Z_RECIP_RST;
      errors  = 0;
    endfunction

    function void set_whites(logic [RECIP_W-1:0] wx, logic [RECIP_W-1:0] wy,
                             logic [RECIP_W-1:0] wz);
      white_x = wx;
      white_y = wy;
      white_z = wz;
    endfunction

    // Largest y with y^3 <= m, built one bit at a time from the top.
    function longint floor_cbrt(longint unsigned m);
      longint unsigned y;
      longint unsigned c;
      y = 0;
      for (int b = 20; b >= 0; b--) begin
        c = y | (64'd1 << b);
        if (c * c * c <= m) begin
          y = c;
        end
      end
      return longint'(y);
    endfunction

    // Companded value in Q.18 for one tristimulus component.
    function longint f18_of(logic signed [TRI_W-1:0] v, logic [RECIP_W-1:0] recip);
      longint t24;
      t24 = (longint'(v) * longint'(recip)) >>> 8;
      if (t24 > CBRT_KNEE_Q24) begin
        return floor_cbrt(longint'(unsigned'(t24)) << 30);
      end
      return ((t24 * SLOPE_Q16) >>> 22) + KNEE_BASE_Q18;
    endfunction

    function logic signed [OUT_W-1:0] round_clamp(longint scaled, longint offset);
      longint r;
      r = ((scaled + 512) >>> 10) + offset;
      if (r > LAB_MAX) begin
        r = LAB_MAX;
      end else if (r < LAB_MIN) begin
        r = LAB_MIN;
      end
      return r[OUT_W-1:0];
    endfunction

    function lab_t lab_of_pixel(logic signed [TRI_W-1:0] x, logic signed [TRI_W-1:0] y,
                                logic signed [TRI_W-1:0] z);
      longint fx;
      longint fy;
      longint fz;
      lab_t   lab;
      fx = f18_of(x, white_x);
      fy = f18_of(y, white_y);
      fz = f18_of(z, white_z);
      lab.l_star = round_clamp(L_SCALE * fy, L_OFFSET);
      lab.a_star = round_clamp(A_SCALE * (fx - fy), 0);
      lab.b_star = round_clamp(B_SCALE * (fy - fz), 0);
      return lab;
    endfunction

    function void note_pixel(logic signed [TRI_W-1:0] x, logic signed [TRI_W-1:0] y,
                             logic signed [TRI_W-1:0] z);
      pending_lab.push_back(lab_of_pixel(x, y, z));
    endfunction

    function void compare_field(string name, logic signed [OUT_W-1:0] want,
                                logic signed [OUT_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic signed [OUT_W-1:0] l, logic signed [OUT_W-1:0] a,
                               logic signed [OUT_W-1:0] b);
      lab_t want;
      if (pending_lab.size() == 0) begin
        $display("%0t: result with no pixel pending, expected none, actual %0d %0d %0d",
                 $time, l, a, b);
        errors++;
        return;
      end
      want = pending_lab.pop_front();
      compare_field("L*", want.l_star, l);
      compare_field("a*", want.a_star, a);
      compare_field("b*", want.b_star, b);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RECIP_W-1:0]   cfg_wdata;

  xyzlab_in_if  in_px();
  xyzlab_out_if out_px();

  xyz_to_cielab_converter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_px    (in_px),
    .out_px   (out_px),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  lab_scoreboard sb = new();
  int            idle_pct    = 20;
  int            stall_left  = 0;
  int            quiet_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: ready drops at random, in bursts of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_px.ready  <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left    <= $urandom_range(0, 17);
      out_px.ready  <= 1'b0;
    end else begin
      out_px.ready  <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_px.valid === 1'b1 && out_px.ready === 1'b1) begin
      sb.check_result(out_px.l_star, out_px.a_star, out_px.b_star);
    end
  end

  always @(posedge clk) begin
    if ((in_px.valid === 1'b1 && in_px.ready === 1'b1) ||
        (out_px.valid === 1'b1 && out_px.ready === 1'b1)) begin
      quiet_count <= 0;
    end else if (quiet_count >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic send_pixel(input logic signed [TRI_W-1:0] x, input logic signed [TRI_W-1:0] y,
                            input logic signed [TRI_W-1:0] z);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_px.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_px.valid     <= 1'b1;
    in_px.x_tristim <= x;
    in_px.y_tristim <= y;
    in_px.z_tristim <= z;
    do @(posedge clk); while (in_px.ready !== 1'b1);
    sb.note_pixel(x, y, z);
  endtask

  // The block must be empty before its white point changes.
  task automatic wait_drained();
    while (sb.pending_lab.size() != 0) @(posedge clk);
  endtask

  task automatic load_whites(input logic [RECIP_W-1:0] wx, input logic [RECIP_W-1:0] wy,
                             input logic [RECIP_W-1:0] wz);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_wdata <= RECIP_W'($urandom());
    @(posedge clk);
    cfg_index <= CFG_X_RECIP;
    cfg_wdata <= wx;
    @(posedge clk);
    cfg_index <= CFG_Y_RECIP;
    cfg_wdata <= wy;
    @(posedge clk);
    cfg_index <= CFG_Z_RECIP;
    cfg_wdata <= wz;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= RECIP_W'($urandom());
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_whites(wx, wy, wz);
  endtask

  function automatic logic signed [TRI_W-1:0] random_tristim();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return TRI_W'($urandom_range(0, 28000));
      4, 5:       return TRI_W'($urandom());
      6, 7:       return TRI_W'(int'($urandom_range(0, 1200)) - 600);
      8:          return TRI_W'(-int'($urandom_range(0, 32768)));
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] random_white();
    if ($urandom_range(0, 1) == 0) begin
      return RECIP_W'($urandom_range(1, 24'hffffff));
    end
    return RECIP_W'($urandom_range(120000, 250000));
  endfunction

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_X_RECIP;
    cfg_wdata       <= '0;
    in_px.valid     <= 1'b0;
    in_px.x_tristim <= '0;
    in_px.y_tristim <= '0;
    in_px.z_tristim <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // Drop valid first so the last item of a phase is not taken twice.
      in_px.valid <= 1'b0;
      wait_drained();
      @(posedge clk);
      case (p)
        0: ;
        1: load_whites(24'd1, 24'd1, 24'd1);
        2: load_whites(24'hffffff, 24'hffffff, 24'hffffff);
        3: load_whites(24'd0, 24'd0, 24'd0);
        4: load_whites(24'd0, Y_RECIP_RST, 24'hffffff);
        PHASES - 1: load_whites(X_RECIP_RST, Y_RECIP_RST, Z_RECIP_RST);
        default: load_whites(random_white(), random_white(), random_white());
      endcase
      // Some phases run without any idling; the last one always does.
      if (p == PHASES - 1 || p % 3 == 1) begin
        idle_pct = 0;
      end else begin
        idle_pct = (p % 3 == 0) ? 25 : 10;
      end

      if (p == 0) begin
        send_pixel(0, 0, 0);
        send_pixel(24332, 25600, 27874);
        send_pixel(32767, 32767, 32767);
        send_pixel(-32768, -32768, -32768);
        send_pixel(32767, -32768, 0);
        send_pixel(-32768, 32767, 32767);
        send_pixel(0, 32767, -32768);
        send_pixel(32767, 0, -32768);
        send_pixel(-32768, 0, 32767);
        send_pixel(1, 1, 1);
        send_pixel(-1, -1, -1);
        // Just below and just above the cube-root knee for each white.
        send_pixel(215, 226, 246);
        send_pixel(216, 227, 247);
        send_pixel(217, 228, 248);
        send_pixel(-215, -226, -246);
        send_pixel(12800, 12800, 12800);
        send_pixel(16'sh5555, 16'shaaaa, 16'sh5555);
        send_pixel(16'shaaaa, 16'sh5555, 16'shaaaa);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        send_pixel(random_tristim(), random_tristim(), random_tristim());
      end
    end
    in_px.valid <= 1'b0;

    wait_drained();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_lab.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
